>>> hw/rtl/dstq_pkg.sv
// package for the deadline sorted timer queue
// holds the shared enums, control structs and fixed constants; no dependencies
`default_nettype none

package dstq_pkg;

  localparam int unsigned ID_W   = 8;
  localparam int unsigned TICK_W = 32;

  localparam logic [TICK_W-1:0] IDLE_DELAY_RESET = 32'd100;

  // input request kinds
  typedef enum logic [1:0] {
    K_QUEUE  = 2'd0,
    K_CANCEL = 2'd1,
    K_POLL   = 2'd2
  } kind_e;

  // result kinds
  typedef enum logic [1:0] {
    RK_STATUS = 2'd0,
    RK_FIRED  = 2'd1,
    RK_SLEEP  = 2'd2
  } rkind_e;

  // status codes
  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_SCAN,
    S_REMOVE,
    S_INSERT,
    S_RESP,
    S_POLL
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    match;
    logic    step;
    logic    remove;
    logic    rm_head;
    logic    insert;
    logic    emit;
    rkind_e  emit_kind;
    status_e emit_status;
    logic    emit_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] kind;
    logic       scan_done;
    logic       scan_hit;
    logic       full;
    logic       head_due;
    logic       slot_free;
  } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/dstq_datapath.sv
// datapath of the timer queue: sorted entry cells, match scan, result register
// depends on dstq_pkg
`default_nettype none

module dstq_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire dstq_pkg::cmd_t                    cmd_i,
  output dstq_pkg::sts_t                         sts_o,
  input  wire logic [1:0]                        kind_i,
  input  wire logic [dstq_pkg::ID_W-1:0]         worker_id_i,
  input  wire logic [dstq_pkg::TICK_W-1:0]       delay_ticks_i,
  input  wire logic [dstq_pkg::TICK_W-1:0]       now_i,
  input  wire logic                              cfg_valid_i,
  input  wire logic [dstq_pkg::TICK_W-1:0]       cfg_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [1:0]                             result_kind_o,
  output logic [1:0]                             status_o,
  output logic [dstq_pkg::ID_W-1:0]              fired_id_o,
  output logic [dstq_pkg::TICK_W-1:0]            sleep_ticks_o,
  output logic                                   last_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned TW = dstq_pkg::TICK_W;
  localparam int unsigned HW = dstq_pkg::ID_W;

  // entry cells, sorted by deadline
  logic [TW-1:0] dl_q [DEPTH];
  logic [HW-1:0] hd_q [DEPTH];
  logic [DEPTH-1:0] match_q;
  logic [DEPTH-1:0] gt;
  logic [DEPTH-1:0] vmask;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] rm_pos;

  // latched request
  logic [1:0]    kind_q;
  logic [HW-1:0] id_q;
  logic [TW-1:0] now_q;
  logic [TW-1:0] new_dl_q;

  logic [TW-1:0] idle_q;

  // result register
  logic          res_valid_q, res_valid_d;
  logic [1:0]    res_kind_q;
  logic [1:0]    res_status_q;
  logic [HW-1:0] res_id_q;
  logic [TW-1:0] res_sleep_q;
  logic          res_last_q;

  logic          slot_free;
  logic          scan_done;
  logic [TW-1:0] sleep_val;

  assign rm_pos    = cmd_i.rm_head ? '0 : idx_q;
  assign scan_done = (idx_q == cnt_q);
  assign slot_free = !res_valid_q || out_ready_i;

  genvar g;
  for (g = 0; g < DEPTH; g++) begin : g_cell
    logic [TW-1:0] up_dl, dn_dl, dl_d;
    logic [HW-1:0] up_hd, dn_hd, hd_d;
    logic          up_gt;

    assign gt[g]    = (CW'(g) >= cnt_q) || (dl_q[g] > new_dl_q);
    assign vmask[g] = (CW'(g) < cnt_q);

    if (g == 0) begin : g_first
      assign up_gt = 1'b0;
      assign up_dl = dl_q[g];
      assign up_hd = hd_q[g];
    end else begin : g_inner
      assign up_gt = gt[g-1];
      assign up_dl = dl_q[g-1];
      assign up_hd = hd_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign dn_dl = dl_q[g];
      assign dn_hd = hd_q[g];
    end else begin : g_below
      assign dn_dl = dl_q[g+1];
      assign dn_hd = hd_q[g+1];
    end

    always_comb begin
      dl_d = dl_q[g];
      hd_d = hd_q[g];
      if (cmd_i.insert) begin
        if (up_gt) begin
          dl_d = up_dl;
          hd_d = up_hd;
        end else if (gt[g]) begin
          dl_d = new_dl_q;
          hd_d = id_q;
        end
      end else if (cmd_i.remove && (CW'(g) >= rm_pos)) begin
        dl_d = dn_dl;
        hd_d = dn_hd;
      end
    end

    always_ff @(posedge clk_i) begin
      dl_q[g] <= dl_d;
      hd_q[g] <= hd_d;
      if (cmd_i.match) begin
        match_q[g] <= (hd_q[g] == id_q);
      end
    end
  end

  // fill count and scan index
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.insert) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.remove) begin
      cnt_d = cnt_q - CW'(1);
    end
    idx_d = idx_q;
    if (cmd_i.match) begin
      idx_d = '0;
    end else if (cmd_i.step) begin
      idx_d = idx_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      idx_q  <= '0;
      idle_q <= dstq_pkg::IDLE_DELAY_RESET;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      if (cfg_valid_i) begin
        idle_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      id_q     <= worker_id_i;
      now_q    <= now_i;
      new_dl_q <= now_i + delay_ticks_i;
    end
  end

  assign sleep_val = (cnt_q != '0) ? (dl_q[0] - now_q) : idle_q;

  // result register
  always_comb begin
    res_valid_d = res_valid_q;
    if (cmd_i.emit) begin
      res_valid_d = 1'b1;
    end else if (out_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_kind_q   <= cmd_i.emit_kind;
      res_status_q <= cmd_i.emit_status;
      res_last_q   <= cmd_i.emit_last;
      res_id_q     <= (cmd_i.emit_kind == dstq_pkg::RK_FIRED) ? hd_q[0] : '0;
      res_sleep_q  <= (cmd_i.emit_kind == dstq_pkg::RK_SLEEP) ? sleep_val : '0;
    end
  end

  assign out_valid_o   = res_valid_q;
  assign result_kind_o = res_kind_q;
  assign status_o      = res_status_q;
  assign fired_id_o    = res_id_q;
  assign sleep_ticks_o = res_sleep_q;
  assign last_o        = res_last_q;

  assign sts_o.kind      = kind_q;
  assign sts_o.scan_done = scan_done;
  assign sts_o.scan_hit  = !scan_done && match_q[idx_q[IW-1:0]];
  assign sts_o.full      = (cnt_q == CW'(DEPTH));
  assign sts_o.head_due  = (cnt_q != '0) && (dl_q[0] <= now_q);
  assign sts_o.slot_free = slot_free;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_no_insert_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |-> (cnt_q != CW'(DEPTH)))
    else $error("insert into full queue");

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> slot_free)
    else $error("result overwritten before taken");

  a_unique_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.match |=> ($countones(match_q & vmask) <= 1))
    else $error("handle stored twice");

endmodule

`default_nettype wire

>>> hw/rtl/dstq_ctrl.sv
// controller of the timer queue: sequences match scan, remove, insert and poll
// depends on dstq_pkg
`default_nettype none

module dstq_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire dstq_pkg::sts_t sts_i,
  output dstq_pkg::cmd_t      cmd_o
);

  dstq_pkg::state_e  state_q, state_d;
  dstq_pkg::status_e resp_q, resp_d;

  // next state
  always_comb begin
    state_d = state_q;
    resp_d  = resp_q;
    case (state_q)
      dstq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = dstq_pkg::S_MATCH;
        end
      end
      dstq_pkg::S_MATCH: begin
        case (sts_i.kind)
          dstq_pkg::K_POLL:   state_d = dstq_pkg::S_POLL;
          dstq_pkg::K_QUEUE:  state_d = dstq_pkg::S_SCAN;
          dstq_pkg::K_CANCEL: state_d = dstq_pkg::S_SCAN;
          default: begin
            resp_d  = dstq_pkg::STS_OK;
            state_d = dstq_pkg::S_RESP;
          end
        endcase
      end
      dstq_pkg::S_SCAN: begin
        if (sts_i.scan_done) begin
          if (sts_i.kind == dstq_pkg::K_QUEUE) begin
            if (sts_i.full) begin
              resp_d  = dstq_pkg::STS_FULL;
              state_d = dstq_pkg::S_RESP;
            end else begin
              state_d = dstq_pkg::S_INSERT;
            end
          end else begin
            resp_d  = dstq_pkg::STS_NOT_FOUND;
            state_d = dstq_pkg::S_RESP;
          end
        end else if (sts_i.scan_hit) begin
          state_d = dstq_pkg::S_REMOVE;
        end
      end
      dstq_pkg::S_REMOVE: begin
        if (sts_i.kind == dstq_pkg::K_QUEUE) begin
          state_d = dstq_pkg::S_INSERT;
        end else begin
          resp_d  = dstq_pkg::STS_OK;
          state_d = dstq_pkg::S_RESP;
        end
      end
      dstq_pkg::S_INSERT: begin
        resp_d  = dstq_pkg::STS_OK;
        state_d = dstq_pkg::S_RESP;
      end
      dstq_pkg::S_RESP: begin
        if (sts_i.slot_free) begin
          state_d = dstq_pkg::S_IDLE;
        end
      end
      dstq_pkg::S_POLL: begin
        if (sts_i.slot_free && !sts_i.head_due) begin
          state_d = dstq_pkg::S_IDLE;
        end
      end
      default: state_d = dstq_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o        = 1'b0;
    cmd_o             = '0;
    cmd_o.emit_kind   = dstq_pkg::RK_STATUS;
    cmd_o.emit_status = dstq_pkg::STS_OK;
    case (state_q)
      dstq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      dstq_pkg::S_MATCH: begin
        cmd_o.match = 1'b1;
      end
      dstq_pkg::S_SCAN: begin
        cmd_o.step = !sts_i.scan_done && !sts_i.scan_hit;
      end
      dstq_pkg::S_REMOVE: begin
        cmd_o.remove = 1'b1;
      end
      dstq_pkg::S_INSERT: begin
        cmd_o.insert = 1'b1;
      end
      dstq_pkg::S_RESP: begin
        cmd_o.emit        = sts_i.slot_free;
        cmd_o.emit_status = resp_q;
        cmd_o.emit_last   = 1'b1;
      end
      dstq_pkg::S_POLL: begin
        cmd_o.emit = sts_i.slot_free;
        if (sts_i.head_due) begin
          cmd_o.emit_kind = dstq_pkg::RK_FIRED;
          cmd_o.remove    = sts_i.slot_free;
          cmd_o.rm_head   = 1'b1;
        end else begin
          cmd_o.emit_kind = dstq_pkg::RK_SLEEP;
          cmd_o.emit_last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dstq_pkg::S_IDLE;
      resp_q  <= dstq_pkg::STS_OK;
    end else begin
      state_q <= state_d;
      resp_q  <= resp_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/deadline_sorted_timer_queue.sv
// top level of the deadline sorted timer queue
// instantiates dstq_ctrl and dstq_datapath; depends on dstq_pkg
//
// usage: requests enter on the in_* valid/ready channel (kind_i: queue, cancel,
// poll). queue stores worker_id_i at deadline now_i + delay_ticks_i (mod 2^32),
// after all entries with equal or earlier deadlines; cancel removes a handle.
// each queue or cancel request returns one status result. a poll returns one
// fired result per entry due at now_i, oldest deadline first, then one sleep
// result; last_o marks the final result of each request.
// the cfg_* channel writes the idle delay (reset 100); it is always ready and
// should only be written while no request is in flight.
// sequence: the match state builds the match flags for the accepted request,
// then the scan walks one entry per cycle from the head until it finds the
// handle or reaches the count. a found handle is removed in the remove state, a
// queue request then inserts in the insert state (or reports full), and the
// result is loaded in the response state. a poll loads its results in turn
// from the poll state, each when the result register is free.
// one request is worked on at a time; the controller returns to idle once the
// last result is loaded and takes the next request there.
// reset empties the queue and drops any pending result. when the receiver
// stalls, the result register holds and the controller waits.
`default_nettype none

module deadline_sorted_timer_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // request channel
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  kind_i,
  input  wire logic [dstq_pkg::ID_W-1:0]   worker_id_i,
  input  wire logic [dstq_pkg::TICK_W-1:0] delay_ticks_i,
  input  wire logic [dstq_pkg::TICK_W-1:0] now_i,
  // result channel
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [1:0]                       result_kind_o,
  output logic [1:0]                       status_o,
  output logic [dstq_pkg::ID_W-1:0]        fired_id_o,
  output logic [dstq_pkg::TICK_W-1:0]      sleep_ticks_o,
  output logic                             last_o,
  // idle delay register write
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [dstq_pkg::TICK_W-1:0] cfg_data_i
);

  dstq_pkg::cmd_t cmd;
  dstq_pkg::sts_t sts;

  // register writes never stall
  assign cfg_ready_o = 1'b1;

  // sequencing of each request
  dstq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // sorted cells, scan and result register
  dstq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .kind_i        (kind_i),
    .worker_id_i   (worker_id_i),
    .delay_ticks_i (delay_ticks_i),
    .now_i         (now_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .status_o      (status_o),
    .fired_id_o    (fired_id_o),
    .sleep_ticks_o (sleep_ticks_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire
